// ----- design/scsa_pkg.sv -----
`timescale 1ns / 1ps

package scsa_pkg;

    // Fixed field widths
    localparam int KIND_W    = 2;
    localparam int SAMPLE_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int TEN_W     = 10;
    localparam int Q8_W      = 24;
    localparam int COUNT_W   = 9;

    // Sample minus limit, and the mapped numerator |diff| * 1023
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int MAP_NUM_W = SAMPLE_W + TEN_W;

    typedef logic [KIND_W-1:0]          t_kind;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Request kinds
    localparam t_kind KIND_MEASURE   = 2'd0;
    localparam t_kind KIND_CAL       = 2'd1;
    localparam t_kind KIND_CAL_RESET = 2'd2;
    localparam t_kind KIND_CLEAR     = 2'd3;

    // Limit reset values
    localparam t_sample CAL_LOW_RST  = 16'sd32000;
    localparam t_sample CAL_HIGH_RST = -16'sd32000;

    // Output scale tops
    localparam logic [BYTE_W-1:0] BYTE_TOP = 8'd255;
    localparam logic [TEN_W-1:0]  TEN_TOP  = 10'd1023;

endpackage

// ----- design/scsa_ram.sv -----
`timescale 1ns / 1ps

module scsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/scsa_div.sv -----
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
// The numerator arrives left-aligned; i_steps is its significant width.
module scsa_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(NUM_W+1)-1:0]     i_steps,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [DEN_W-1:0]               i_den,
    output logic                           o_done,
    output logic [NUM_W-1:0]               o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    // Shift in one numerator bit and try the subtract
    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- design/sensor_calibrate_scale_average_unit.sv -----
`timescale 1ns / 1ps
// Flow: a request passes the update step, then up to four divisions on the shared
//   one-bit-per-cycle divider (byte map, ten-bit map, Q8 average, averaged map) in turn;
//   a division that is skipped does not start the divider. The input stalls until the
//   result is registered, so a new request is taken only after the last one is through,
//   and a stalled result holds the next request in its last step.
// Reset: synchronous active low; limits go to 32000 / -32000, sum, slot and count to zero.
module sensor_calibrate_scale_average_unit #(
    parameter int WINDOW = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [scsa_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [scsa_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [scsa_pkg::BYTE_W-1:0]         o_scaled_byte,
    output logic [scsa_pkg::TEN_W-1:0]          o_scaled_ten_bit,
    output logic signed [scsa_pkg::Q8_W-1:0]    o_average_q8,
    output logic [scsa_pkg::BYTE_W-1:0]         o_scaled_average,
    output logic                                o_average_valid,
    output logic signed [scsa_pkg::SAMPLE_W-1:0] o_cal_low_out,
    output logic signed [scsa_pkg::SAMPLE_W-1:0] o_cal_high_out,
    output logic [scsa_pkg::COUNT_W-1:0]        o_window_count
);

    // Window entries are not cleared; an entry is read on every accept but only used once it has been written.

    localparam int SAMPLE_W  = scsa_pkg::SAMPLE_W;
    localparam int DIFF_W    = scsa_pkg::DIFF_W;
    localparam int MAP_NUM_W = scsa_pkg::MAP_NUM_W;
    localparam int BYTE_W    = scsa_pkg::BYTE_W;
    localparam int TEN_W     = scsa_pkg::TEN_W;
    localparam int Q8_W      = scsa_pkg::Q8_W;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int AVG_NUM_W = SUM_W + 8;
    localparam int DIV_NUM_W = (AVG_NUM_W > MAP_NUM_W) ? AVG_NUM_W : MAP_NUM_W;
    localparam int DEN_W     = SAMPLE_W;
    localparam int STEP_W    = $clog2(DIV_NUM_W + 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Division jobs, in order
    localparam logic [1:0] OP_SB  = 2'd0;
    localparam logic [1:0] OP_ST  = 2'd1;
    localparam logic [1:0] OP_AVG = 2'd2;
    localparam logic [1:0] OP_SA  = 2'd3;

    // Control state
    logic [2:0]                r_state, n_state;
    logic [1:0]                r_op, n_op;
    logic                      r_out_valid, n_out_valid;
    scsa_pkg::t_sample         r_cal_low, n_cal_low;
    scsa_pkg::t_sample         r_cal_high, n_cal_high;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [IDX_W-1:0]          r_slot, n_slot;
    logic [CNT_W-1:0]          r_count, n_count;

    // Payload
    scsa_pkg::t_kind           r_kind, n_kind;
    scsa_pkg::t_sample         r_sample, n_sample;
    logic [SUM_W-1:0]          r_nmag, n_nmag;
    logic [DEN_W-1:0]          r_dmag, n_dmag;
    logic                      r_neg, n_neg;
    logic [BYTE_W-1:0]         r_sb, n_sb;
    logic [TEN_W-1:0]          r_st, n_st;
    logic [BYTE_W-1:0]         r_sa, n_sa;
    logic signed [Q8_W-1:0]    r_q8, n_q8;
    scsa_pkg::t_sample         r_avg, n_avg;
    logic [BYTE_W-1:0]         r_o_sb, n_o_sb;
    logic [TEN_W-1:0]          r_o_st, n_o_st;
    logic [BYTE_W-1:0]         r_o_sa, n_o_sa;
    logic signed [Q8_W-1:0]    r_o_q8, n_o_q8;
    scsa_pkg::t_sample         r_o_low, n_o_low;
    scsa_pkg::t_sample         r_o_high, n_o_high;
    logic [scsa_pkg::COUNT_W-1:0] r_o_count, n_o_count;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_map_kind;
    logic [SAMPLE_W-1:0]       w_old;
    scsa_pkg::t_sample         w_x;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DIFF_W-1:0]  w_den;
    logic [DIFF_W-1:0]         w_diff_abs;
    logic [DIFF_W-1:0]         w_den_abs;
    logic [SUM_W-1:0]          w_sum_abs;
    logic                      w_map_zero;
    logic                      w_op_zero;
    logic [MAP_NUM_W-1:0]      w_m;
    logic [MAP_NUM_W-1:0]      w_prod;
    logic [AVG_NUM_W-1:0]      w_avg_num;
    logic [DIV_NUM_W-1:0]      w_div_num;
    logic [STEP_W-1:0]         w_div_steps;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [DIV_NUM_W-1:0]      w_quot;
    logic [BYTE_W-1:0]         w_q_byte;
    logic [TEN_W-1:0]          w_q_ten;
    logic [Q8_W-1:0]           w_q8_mag;
    logic [SAMPLE_W-1:0]       w_avg_mag;
    logic                      w_ram_we;

    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_count == CNT_W'(WINDOW));
    assign w_map_kind = (r_kind == scsa_pkg::KIND_MEASURE) || (r_kind == scsa_pkg::KIND_CAL);

    // Map operand: sample, or the truncated average for the last job
    assign w_x        = (r_op == OP_SA) ? r_avg : r_sample;
    assign w_diff     = DIFF_W'(w_x) - DIFF_W'(r_cal_low);
    assign w_den      = DIFF_W'(r_cal_high) - DIFF_W'(r_cal_low);
    assign w_diff_abs = w_diff[DIFF_W-1] ? -w_diff : w_diff;
    assign w_den_abs  = w_den[DIFF_W-1] ? -w_den : w_den;
    assign w_sum_abs  = r_sum[SUM_W-1] ? -r_sum : r_sum;

    // Zero range, zero offset or opposite signs all clamp to zero
    assign w_map_zero = (w_den == '0) || (w_diff == '0) ||
                        (w_diff[DIFF_W-1] != w_den[DIFF_W-1]);

    always_comb begin
        case (r_op)
            OP_SB, OP_ST: w_op_zero = !w_map_kind || w_map_zero;
            OP_AVG:       w_op_zero = (r_count == '0);
            OP_SA:        w_op_zero = (r_count == '0) || w_map_zero;
            default:      w_op_zero = 1'b1;
        endcase
    end

    // Constant scale by shift and subtract, then left-align for the divider
    assign w_m       = MAP_NUM_W'(r_nmag[SAMPLE_W-1:0]);
    assign w_prod    = (r_op == OP_ST) ? ((w_m << TEN_W) - w_m) : ((w_m << BYTE_W) - w_m);
    assign w_avg_num = {r_nmag, 8'b0};
    assign w_div_num = (r_op == OP_AVG) ?
                       (DIV_NUM_W'(w_avg_num) << (DIV_NUM_W - AVG_NUM_W)) :
                       (DIV_NUM_W'(w_prod) << (DIV_NUM_W - MAP_NUM_W));
    assign w_div_steps = (r_op == OP_AVG) ? STEP_W'(AVG_NUM_W) : STEP_W'(MAP_NUM_W);
    assign w_div_start = (r_state == ST_START);

    // Quotient clamps and the signed average pieces
    assign w_q_byte  = (w_quot > DIV_NUM_W'(scsa_pkg::BYTE_TOP)) ?
                       scsa_pkg::BYTE_TOP : w_quot[BYTE_W-1:0];
    assign w_q_ten   = (w_quot > DIV_NUM_W'(scsa_pkg::TEN_TOP)) ?
                       scsa_pkg::TEN_TOP : w_quot[TEN_W-1:0];
    assign w_q8_mag  = w_quot[Q8_W-1:0];
    assign w_avg_mag = w_quot[Q8_W-1:8];

    // Shared divider
    scsa_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_steps (w_div_steps),
        .i_num   (w_div_num),
        .i_den   (r_dmag),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Window ring: read the oldest slot on accept, write the new measurement into it in the update step
    assign w_ram_we = (r_state == ST_UPD) && (r_kind == scsa_pkg::KIND_MEASURE);

    scsa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_old)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        n_cal_low   = r_cal_low;
        n_cal_high  = r_cal_high;
        n_sum       = r_sum;
        n_slot      = r_slot;
        n_count     = r_count;
        n_kind      = r_kind;
        n_sample    = r_sample;
        n_nmag      = r_nmag;
        n_dmag      = r_dmag;
        n_neg       = r_neg;
        n_sb        = r_sb;
        n_st        = r_st;
        n_sa        = r_sa;
        n_q8        = r_q8;
        n_avg       = r_avg;
        n_o_sb      = r_o_sb;
        n_o_st      = r_o_st;
        n_o_sa      = r_o_sa;
        n_o_q8      = r_o_q8;
        n_o_low     = r_o_low;
        n_o_high    = r_o_high;
        n_o_count   = r_o_count;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind   = i_kind;
                    n_sample = i_sample_value;
                    n_state  = ST_UPD;
                end
            end
            ST_UPD: begin
                case (r_kind)
                    scsa_pkg::KIND_MEASURE: begin
                        n_sum = r_sum - (w_full ? SUM_W'($signed(w_old)) : '0) +
                                SUM_W'(r_sample);
                        n_slot = (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + IDX_W'(1);
                        if (!w_full) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    scsa_pkg::KIND_CAL: begin
                        if (r_sample > r_cal_high) begin
                            n_cal_high = r_sample;
                        end
                        if (r_sample < r_cal_low) begin
                            n_cal_low = r_sample;
                        end
                    end
                    scsa_pkg::KIND_CAL_RESET: begin
                        n_cal_low  = scsa_pkg::CAL_LOW_RST;
                        n_cal_high = scsa_pkg::CAL_HIGH_RST;
                    end
                    default: begin
                        n_sum   = '0;
                        n_slot  = '0;
                        n_count = '0;
                    end
                endcase
                n_op    = OP_SB;
                n_state = ST_PREP;
            end
            ST_PREP: begin
                if (w_op_zero) begin
                    case (r_op)
                        OP_SB:   n_sb = '0;
                        OP_ST:   n_st = '0;
                        OP_AVG: begin
                            n_q8  = '0;
                            n_avg = '0;
                        end
                        default: n_sa = '0;
                    endcase
                    if (r_op == OP_SA) begin
                        n_state = ST_DONE;
                    end else begin
                        n_op = r_op + 2'd1;
                    end
                end else begin
                    n_neg = r_sum[SUM_W-1];
                    if (r_op == OP_AVG) begin
                        n_nmag = w_sum_abs;
                        n_dmag = DEN_W'(r_count);
                    end else begin
                        n_nmag = SUM_W'(w_diff_abs[SAMPLE_W-1:0]);
                        n_dmag = w_den_abs[SAMPLE_W-1:0];
                    end
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    case (r_op)
                        OP_SB:   n_sb = w_q_byte;
                        OP_ST:   n_st = w_q_ten;
                        OP_AVG: begin
                            n_q8  = r_neg ? -$signed(w_q8_mag) : $signed(w_q8_mag);
                            n_avg = r_neg ? -$signed(w_avg_mag) : $signed(w_avg_mag);
                        end
                        default: n_sa = w_q_byte;
                    endcase
                    if (r_op == OP_SA) begin
                        n_state = ST_DONE;
                    end else begin
                        n_op    = r_op + 2'd1;
                        n_state = ST_PREP;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_o_sb      = r_sb;
                    n_o_st      = r_st;
                    n_o_sa      = r_sa;
                    n_o_q8      = r_q8;
                    n_o_low     = r_cal_low;
                    n_o_high    = r_cal_high;
                    n_o_count   = scsa_pkg::COUNT_W'(r_count);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_SB;
            r_out_valid <= 1'b0;
            r_cal_low   <= scsa_pkg::CAL_LOW_RST;
            r_cal_high  <= scsa_pkg::CAL_HIGH_RST;
            r_sum       <= '0;
            r_slot      <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
            r_cal_low   <= n_cal_low;
            r_cal_high  <= n_cal_high;
            r_sum       <= n_sum;
            r_slot      <= n_slot;
            r_count     <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_sample  <= n_sample;
        r_nmag    <= n_nmag;
        r_dmag    <= n_dmag;
        r_neg     <= n_neg;
        r_sb      <= n_sb;
        r_st      <= n_st;
        r_sa      <= n_sa;
        r_q8      <= n_q8;
        r_avg     <= n_avg;
        r_o_sb    <= n_o_sb;
        r_o_st    <= n_o_st;
        r_o_sa    <= n_o_sa;
        r_o_q8    <= n_o_q8;
        r_o_low   <= n_o_low;
        r_o_high  <= n_o_high;
        r_o_count <= n_o_count;
    end

    assign o_stall          = (r_state != ST_IDLE) || !i_rst_n;
    assign o_valid          = r_out_valid;
    assign o_scaled_byte    = r_o_sb;
    assign o_scaled_ten_bit = r_o_st;
    assign o_average_q8     = r_o_q8;
    assign o_scaled_average = r_o_sa;
    assign o_average_valid  = (r_o_count != '0);
    assign o_cal_low_out    = r_o_low;
    assign o_cal_high_out   = r_o_high;
    assign o_window_count   = r_o_count;

endmodule

// ----- design/scsa_checker.sv -----
`timescale 1ns / 1ps

module scsa_checker #(
    parameter int WINDOW = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic [scsa_pkg::KIND_W-1:0]          i_kind,
    input logic signed [scsa_pkg::SAMPLE_W-1:0] i_sample_value,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [scsa_pkg::BYTE_W-1:0]          o_scaled_byte,
    input logic [scsa_pkg::TEN_W-1:0]           o_scaled_ten_bit,
    input logic signed [scsa_pkg::Q8_W-1:0]     o_average_q8,
    input logic [scsa_pkg::BYTE_W-1:0]          o_scaled_average,
    input logic                                 o_average_valid,
    input logic signed [scsa_pkg::SAMPLE_W-1:0] o_cal_low_out,
    input logic signed [scsa_pkg::SAMPLE_W-1:0] o_cal_high_out,
    input logic [scsa_pkg::COUNT_W-1:0]         o_window_count
);

    // A taken request blocks the input while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a request was taken");

    // Held result does not change while stalled
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_scaled_byte) &&
        $stable(o_average_q8) && $stable(o_window_count) && $stable(o_cal_low_out))
        else $error("stalled result changed");

    // Count bounds and the valid flag agree
    a_count_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_average_valid == (o_window_count != '0)) &&
        (o_window_count <= scsa_pkg::COUNT_W'(WINDOW)))
        else $error("window count and average flag disagree");

    // Empty window gives zero average fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_average_valid |-> (o_average_q8 == '0) && (o_scaled_average == '0))
        else $error("empty window with nonzero average");

    // Equal limits map everything to zero
    a_equal_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_cal_high_out == o_cal_low_out) |->
        (o_scaled_byte == '0) && (o_scaled_ten_bit == '0) && (o_scaled_average == '0))
        else $error("nonzero map with equal limits");

endmodule

bind sensor_calibrate_scale_average_unit scsa_checker #(.WINDOW(WINDOW)) u_scsa_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import scsa_pkg::*;

    localparam int WINDOW        = 16;
    localparam int PHASE_ITEMS   = 550;
    localparam int HOLD_CYCLES   = 500;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int REPORT_CAP    = 100;
    localparam int DIRECTED_ROWS = 18;

    // One result of the block, in port order
    typedef struct packed {
        logic [BYTE_W-1:0]          scaled_byte;
        logic [TEN_W-1:0]           scaled_ten_bit;
        logic signed [Q8_W-1:0]     average_q8;
        logic [BYTE_W-1:0]          scaled_average;
        logic                       average_valid;
        logic signed [SAMPLE_W-1:0] cal_low_out;
        logic signed [SAMPLE_W-1:0] cal_high_out;
        logic [COUNT_W-1:0]         window_count;
    } t_scaled_result;

    // Directed row: request plus an optional hand-written result
    typedef struct packed {
        t_kind          kind;
        t_sample        sample;
        logic           typed;
        t_scaled_result result;
    } t_stim_row;

    localparam t_scaled_result NO_RESULT = '0;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [KIND_W-1:0]            i_kind = '0;
    logic signed [SAMPLE_W-1:0]   i_sample_value = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [BYTE_W-1:0]            o_scaled_byte;
    logic [TEN_W-1:0]             o_scaled_ten_bit;
    logic signed [Q8_W-1:0]       o_average_q8;
    logic [BYTE_W-1:0]            o_scaled_average;
    logic                         o_average_valid;
    logic signed [SAMPLE_W-1:0]   o_cal_low_out;
    logic signed [SAMPLE_W-1:0]   o_cal_high_out;
    logic [COUNT_W-1:0]           o_window_count;

    // Predicted calibration and averaging state
    int cal_lo_q = int'(CAL_LOW_RST);
    int cal_hi_q = int'(CAL_HIGH_RST);
    int ring_q [WINDOW];
    int sum_q    = 0;
    int slot_q   = 0;
    int fill_q   = 0;

    t_scaled_result pending_results[$];
    int             mismatches    = 0;
    int             results_seen  = 0;
    int             quiet_cycles  = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    bit             hold_request  = 1'b0;
    int             burst_left    = 0;
    t_sample        burst_value   = '0;

    // Directed requests: extremes, every kind, equal and inverted limits
    t_stim_row directed_table [DIRECTED_ROWS] = '{
        '{KIND_CAL_RESET, 16'sh1234, 1'b1,
          '{8'd0, 10'd0, 24'sd0, 8'd0, 1'b0, CAL_LOW_RST, CAL_HIGH_RST, 9'd0}},
        '{KIND_CLEAR, 16'sh7fff, 1'b1,
          '{8'd0, 10'd0, 24'sd0, 8'd0, 1'b0, CAL_LOW_RST, CAL_HIGH_RST, 9'd0}},
        '{KIND_MEASURE, 16'sd100, 1'b0, NO_RESULT},
        '{KIND_MEASURE, 16'sh8000, 1'b0, NO_RESULT},
        '{KIND_CAL, 16'sd0, 1'b0, NO_RESULT},
        '{KIND_MEASURE, 16'sd5, 1'b0, NO_RESULT},
        '{KIND_CLEAR, 16'sh8000, 1'b1,
          '{8'd0, 10'd0, 24'sd0, 8'd0, 1'b0, 16'sd0, 16'sd0, 9'd0}},
        '{KIND_CAL, 16'sh8000, 1'b1,
          '{8'd0, 10'd0, 24'sd0, 8'd0, 1'b0, 16'sh8000, 16'sd0, 9'd0}},
        '{KIND_CAL, 16'sh7fff, 1'b1,
          '{BYTE_TOP, TEN_TOP, 24'sd0, 8'd0, 1'b0, 16'sh8000, 16'sh7fff, 9'd0}},
        '{KIND_MEASURE, 16'sh7fff, 1'b1,
          '{BYTE_TOP, TEN_TOP, 24'sd8388352, BYTE_TOP, 1'b1, 16'sh8000, 16'sh7fff, 9'd1}},
        '{KIND_MEASURE, 16'sh8000, 1'b0, NO_RESULT},
        '{KIND_MEASURE, 16'sd0, 1'b0, NO_RESULT},
        '{KIND_CAL, 16'sh5555, 1'b0, NO_RESULT},
        '{KIND_CAL, 16'shaaaa, 1'b0, NO_RESULT},
        '{KIND_CAL_RESET, 16'shffff, 1'b0, NO_RESULT},
        '{KIND_MEASURE, 16'sh7fff, 1'b0, NO_RESULT},
        '{KIND_MEASURE, 16'sh8000, 1'b0, NO_RESULT},
        '{KIND_CLEAR, 16'sd0, 1'b1,
          '{8'd0, 10'd0, 24'sd0, 8'd0, 1'b0, CAL_LOW_RST, CAL_HIGH_RST, 9'd0}}
    };

    sensor_calibrate_scale_average_unit #(
        .WINDOW(WINDOW)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_sample_value   (i_sample_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_scaled_byte    (o_scaled_byte),
        .o_scaled_ten_bit (o_scaled_ten_bit),
        .o_average_q8     (o_average_q8),
        .o_scaled_average (o_scaled_average),
        .o_average_valid  (o_average_valid),
        .o_cal_low_out    (o_cal_low_out),
        .o_cal_high_out   (o_cal_high_out),
        .o_window_count   (o_window_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Map x from the current low..high onto 0..top, truncate, clamp
    function automatic int map_onto(int x, int top);
        longint span;
        longint q;
        span = longint'(cal_hi_q) - longint'(cal_lo_q);
        if (span == 0) begin
            return 0;
        end
        q = ((longint'(x) - longint'(cal_lo_q)) * longint'(top)) / span;
        if (q < 0) begin
            q = 0;
        end
        if (q > top) begin
            q = top;
        end
        return int'(q);
    endfunction

    // Advance the predicted state by one request and build its result
    function automatic t_scaled_result calibrate_and_average(t_kind k, t_sample s);
        t_scaled_result r;
        longint mean;
        r = '0;
        case (k)
            KIND_MEASURE: begin
                if (fill_q >= WINDOW) begin
                    sum_q -= ring_q[slot_q];
                end
                ring_q[slot_q] = int'(s);
                sum_q += int'(s);
                slot_q = (slot_q + 1) % WINDOW;
                if (fill_q < WINDOW) begin
                    fill_q++;
                end
            end
            KIND_CAL: begin
                if (int'(s) > cal_hi_q) begin
                    cal_hi_q = int'(s);
                end
                if (int'(s) < cal_lo_q) begin
                    cal_lo_q = int'(s);
                end
            end
            KIND_CAL_RESET: begin
                cal_lo_q = int'(CAL_LOW_RST);
                cal_hi_q = int'(CAL_HIGH_RST);
            end
            KIND_CLEAR: begin
                sum_q  = 0;
                slot_q = 0;
                fill_q = 0;
            end
        endcase
        // reset and clear requests carry no sample to map
        if (k == KIND_MEASURE || k == KIND_CAL) begin
            r.scaled_byte    = BYTE_W'(map_onto(int'(s), int'(BYTE_TOP)));
            r.scaled_ten_bit = TEN_W'(map_onto(int'(s), int'(TEN_TOP)));
        end
        if (fill_q != 0) begin
            mean               = longint'(sum_q) / fill_q;
            r.average_q8       = Q8_W'((longint'(sum_q) * 256) / fill_q);
            r.scaled_average   = BYTE_W'(map_onto(int'(mean), int'(BYTE_TOP)));
            r.average_valid    = 1'b1;
        end
        r.cal_low_out  = SAMPLE_W'(cal_lo_q);
        r.cal_high_out = SAMPLE_W'(cal_hi_q);
        r.window_count = COUNT_W'(fill_q);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < REPORT_CAP) begin
            $display("ERROR result %0d: %s", results_seen, msg);
        end
        mismatches++;
    endtask

    task automatic check_result(t_scaled_result got, t_scaled_result exp);
        if (got.scaled_byte !== exp.scaled_byte)
            report_mismatch($sformatf("scaled_byte %0d, expected %0d",
                                      got.scaled_byte, exp.scaled_byte));
        if (got.scaled_ten_bit !== exp.scaled_ten_bit)
            report_mismatch($sformatf("scaled_ten_bit %0d, expected %0d",
                                      got.scaled_ten_bit, exp.scaled_ten_bit));
        if (got.average_q8 !== exp.average_q8)
            report_mismatch($sformatf("average_q8 %0d, expected %0d",
                                      got.average_q8, exp.average_q8));
        if (got.scaled_average !== exp.scaled_average)
            report_mismatch($sformatf("scaled_average %0d, expected %0d",
                                      got.scaled_average, exp.scaled_average));
        if (got.average_valid !== exp.average_valid)
            report_mismatch($sformatf("average_valid %0d, expected %0d",
                                      got.average_valid, exp.average_valid));
        if (got.cal_low_out !== exp.cal_low_out)
            report_mismatch($sformatf("cal_low_out %0d, expected %0d",
                                      got.cal_low_out, exp.cal_low_out));
        if (got.cal_high_out !== exp.cal_high_out)
            report_mismatch($sformatf("cal_high_out %0d, expected %0d",
                                      got.cal_high_out, exp.cal_high_out));
        if (got.window_count !== exp.window_count)
            report_mismatch($sformatf("window_count %0d, expected %0d",
                                      got.window_count, exp.window_count));
    endtask

    // Offer one request from a falling edge until accepted; returns at a falling edge
    task automatic send_request(t_kind k, t_sample s, bit typed, t_scaled_result typed_res);
        t_scaled_result predicted;
        i_valid        <= 1'b1;
        i_kind         <= k;
        i_sample_value <= s;
        do @(posedge i_clk); while (o_stall);
        predicted = calibrate_and_average(k, s);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // Random sender gap, mostly short, sometimes longer than one request
    task automatic maybe_idle();
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 8);
            i_valid        <= 1'b0;
            i_sample_value <= t_sample'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Mostly measurements and calibration, with runs of one extreme value
    // that fill the ring and push the average to its limits
    task automatic next_random_request(output t_kind k, output t_sample s);
        int pick;
        if (burst_left == 0 && $urandom_range(99) < 2) begin
            burst_left  = $urandom_range(17, 22);
            burst_value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        if (burst_left > 0) begin
            burst_left--;
            k = KIND_MEASURE;
            s = burst_value;
        end else begin
            pick = $urandom_range(99);
            if (pick < 6)
                k = KIND_CLEAR;
            else if (pick < 10)
                k = KIND_CAL_RESET;
            else if (pick < 30)
                k = KIND_CAL;
            else
                k = KIND_MEASURE;
            case ($urandom_range(7))
                0: s = 16'sh8000;
                1: s = 16'sh7fff;
                2: s = t_sample'(int'($urandom_range(200)) - 100);
                3: begin
                    if (cal_hi_q > cal_lo_q)
                        s = t_sample'(cal_lo_q + int'($urandom_range(cal_hi_q - cal_lo_q)));
                    else
                        s = t_sample'($urandom);
                end
                default: s = t_sample'($urandom);
            endcase
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result checking and no-progress watchdog
    always @(posedge i_clk) begin : result_monitor
        t_scaled_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_scaled_byte, o_scaled_ten_bit, o_average_q8, o_scaled_average,
                    o_average_valid, o_cal_low_out, o_cal_high_out, o_window_count};
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
                check_result(got, pending_results.pop_front());
            results_seen++;
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_kind   k;
        t_sample s;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: sender idles lightly, receiver stalls heavily
        send_idle_pct  = 11;
        recv_stall_pct = 47;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            maybe_idle();
            send_request(directed_table[r].kind, directed_table[r].sample,
                         directed_table[r].typed, directed_table[r].result);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 11; recv_stall_pct = 47; end
                1: begin send_idle_pct = 47; recv_stall_pct = 11; end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // back up the block while requests keep coming
                    hold_request   = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                next_random_request(k, s);
                maybe_idle();
                send_request(k, s, 1'b0, NO_RESULT);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
